// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mwpf_pkg.sv =====
// ----------------------------------------------------------------------------
// mwpf_pkg
// panel geometry, field widths, register indexes and result layout for the
// mirrored window pixel fetch block
// ----------------------------------------------------------------------------
package mwpf_pkg;

	// panel geometry in pixels and rows
	localparam int PANEL_WIDTH  = 1872;
	localparam int PANEL_HEIGHT = 1404;
	// frame buffer row pitch in bytes, two pixels per byte
	localparam int PITCH        = PANEL_WIDTH / 2;

	// field widths
	localparam int COORD_W = 13;
	localparam int WIN_W   = 11;
	localparam int ADDR_W  = 21;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 3;
	// signed width for clamping math, holds sums of two coordinates plus rounding
	localparam int CALC_W  = COORD_W + 2;
	// bytes per window row and rows per window
	localparam int RB_W    = $clog2(PANEL_WIDTH / 2 + 1);
	localparam int ROW_W   = $clog2(PANEL_HEIGHT + 1);

	// stream widths
	localparam int TDATA_USED = 4 * WIN_W + ADDR_W + BYTE_W;
	localparam int TDATA_W    = ((TDATA_USED + 7) / 8) * 8;
	localparam int TUSER_W    = 4;

	localparam logic signed [CALC_W-1:0] PANEL_WIDTH_S  = CALC_W'(PANEL_WIDTH);
	localparam logic signed [CALC_W-1:0] PANEL_HEIGHT_S = CALC_W'(PANEL_HEIGHT);
	localparam logic [ADDR_W-1:0]        PITCH_C        = ADDR_W'(PITCH);

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_RECT_LEFT     = 3'd0,
		REG_RECT_TOP      = 3'd1,
		REG_RECT_WIDTH    = 3'd2,
		REG_RECT_HEIGHT   = 3'd3,
		REG_MIRROR_ENABLE = 3'd4
	} reg_idx_t;

	// input item kinds
	typedef enum logic {
		REQ_START = 1'b0,
		REQ_DATA  = 1'b1
	} req_type_t;

	// one result item
	typedef struct packed {
		logic [WIN_W-1:0]  win_x;
		logic [WIN_W-1:0]  win_y;
		logic [WIN_W-1:0]  win_w;
		logic [WIN_W-1:0]  win_h;
		logic              window_empty;
		logic [ADDR_W-1:0] fetch_addr;
		logic              fetch_valid;
		logic [BYTE_W-1:0] out_byte;
		logic              out_valid;
		logic              row_end;
		logic              window_end;
	} result_t;

	// swap the two pixels of a byte
	function automatic logic [BYTE_W-1:0] swap_nibbles(input logic [BYTE_W-1:0] b);
		return {b[3:0], b[7:4]};
	endfunction

endpackage

// ===== sv/mirrored_window_pixel_fetch_top.sv =====
// ----------------------------------------------------------------------------
// mirrored_window_pixel_fetch_top
// clamps and aligns a 4 bpp window, then sequences frame buffer byte fetches
// and returns each fetched byte, mirrored per row when enabled
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata fetched_byte, tuser req_type
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata window + addr + byte,
//                                                tuser flags, tlast window_end
//  cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
//  one result per transaction, a new transaction accepted every cycle while m_axis does not stall
//  an item passes through the input register, then window/fetch logic into the
//  result register; the start path (clamp, row multiply, address add) is the
//  longest path between them
//  arst_n clears valids, busy state and config (mirror_enable resets to 1)
//  a stall on m_axis holds the result register and backs up into s_axis
//  once the input register is also full; cfg_ready is always high
// ----------------------------------------------------------------------------
module mirrored_window_pixel_fetch_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [mwpf_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] fetched_byte
	input  logic                          s_axis_tuser,  // [0] req_type
	// result stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [10:0] win_x, [21:11] win_y, [32:22] win_w, [43:33] win_h,
	// [64:44] fetch_addr, [72:65] out_byte, rest zero
	output logic [mwpf_pkg::TDATA_W-1:0]  m_axis_tdata,
	// [0] window_empty, [1] fetch_valid, [2] out_valid, [3] row_end
	output logic [mwpf_pkg::TUSER_W-1:0]  m_axis_tuser,
	output logic                          m_axis_tlast,  // window_end
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mwpf_pkg::IDX_W-1:0]    cfg_index,
	input  logic [mwpf_pkg::COORD_W-1:0]  cfg_data
);
	import mwpf_pkg::*;

	// configuration registers
	logic signed [COORD_W-1:0] rect_left_q, rect_top_q, rect_width_q, rect_height_q;
	logic                      mirror_q;

	// window state
	logic [RB_W-1:0]   row_bytes_q, byte_count_q;
	logic [ROW_W-1:0]  rows_total_q, row_count_q;
	logic [ADDR_W-1:0] row_base_q;
	logic              busy_q;

	// pipeline registers
	logic              vld_s1, vld_s2;
	logic              req_s1;
	logic [BYTE_W-1:0] byte_s1;
	result_t           res_s2;

	logic    fire;
	result_t res_nxt;

	// start path
	logic signed [CALC_W-1:0] x, y, w, h, x0, x1, xw, aw, seg;
	logic                     st_empty;
	logic [ADDR_W-1:0]        st_base, st_off;

	// data path
	logic                     rend, wend;
	logic [RB_W-1:0]          bc_nxt, off;
	logic [ROW_W-1:0]         rc_nxt;
	logic [ADDR_W-1:0]        base_nxt;

	// handshakes
	assign fire          = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || fire;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = vld_s2;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q   <= '0;
			rect_top_q    <= '0;
			rect_width_q  <= '0;
			rect_height_q <= '0;
			mirror_q      <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RECT_LEFT:     rect_left_q   <= cfg_data;
				REG_RECT_TOP:      rect_top_q    <= cfg_data;
				REG_RECT_WIDTH:    rect_width_q  <= cfg_data;
				REG_RECT_HEIGHT:   rect_height_q <= cfg_data;
				REG_MIRROR_ENABLE: mirror_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	// clamp the rectangle to the panel and widen x to 4-pixel alignment
	always_comb begin
		x = CALC_W'(rect_left_q);
		y = CALC_W'(rect_top_q);
		w = CALC_W'(rect_width_q);
		h = CALC_W'(rect_height_q);
		if (x < 0) begin
			w = w + x;
			x = '0;
		end
		if (y < 0) begin
			h = h + y;
			y = '0;
		end
		if (x + w > PANEL_WIDTH_S) w = PANEL_WIDTH_S - x;
		if (y + h > PANEL_HEIGHT_S) h = PANEL_HEIGHT_S - y;
		x0 = {x[CALC_W-1:2], 2'b00};
		xw = x + w + CALC_W'(3);
		x1 = {xw[CALC_W-1:2], 2'b00};
		if (x1 > PANEL_WIDTH_S) x1 = PANEL_WIDTH_S;
		aw = x1 - x0;
		seg = aw >>> 1;
		st_empty = (w <= 0) || (h <= 0) || (seg <= 0);
		st_base = ADDR_W'(ADDR_W'(y[CALC_W-2:0]) * PITCH_C) + ADDR_W'(x0[CALC_W-2:1]);
		st_off = mirror_q ? ADDR_W'(seg[CALC_W-2:0] - 1'b1) : '0;
	end

	// row and window ends, next fetch position
	always_comb begin
		rend = ({1'b0, byte_count_q} + 1'b1) >= {1'b0, row_bytes_q};
		wend = rend && (({1'b0, row_count_q} + 1'b1) >= {1'b0, rows_total_q});
		bc_nxt   = rend ? '0 : byte_count_q + 1'b1;
		rc_nxt   = rend ? row_count_q + 1'b1 : row_count_q;
		base_nxt = rend ? row_base_q + PITCH_C : row_base_q;
		off      = mirror_q ? row_bytes_q - 1'b1 - bc_nxt : bc_nxt;
	end

	// result for the item in the input register
	always_comb begin
		res_nxt = '0;
		if (req_s1 == REQ_START) begin
			if (st_empty) begin
				res_nxt.window_empty = 1'b1;
			end else begin
				res_nxt.win_x = mirror_q ? WIN_W'(PANEL_WIDTH_S - x1) : WIN_W'(x0);
				res_nxt.win_y       = WIN_W'(y);
				res_nxt.win_w       = WIN_W'(aw);
				res_nxt.win_h       = WIN_W'(h);
				res_nxt.fetch_addr  = st_base + st_off;
				res_nxt.fetch_valid = 1'b1;
			end
		end else if (busy_q) begin
			res_nxt.out_byte   = mirror_q ? swap_nibbles(byte_s1) : byte_s1;
			res_nxt.out_valid  = 1'b1;
			res_nxt.row_end    = rend;
			res_nxt.window_end = wend;
			if (!wend) begin
				res_nxt.fetch_addr  = base_nxt + ADDR_W'(off);
				res_nxt.fetch_valid = 1'b1;
			end
		end
	end

	// window state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q  <= '0;
			byte_count_q <= '0;
			rows_total_q <= '0;
			row_count_q  <= '0;
			row_base_q   <= '0;
			busy_q       <= 1'b0;
		end else if (fire) begin
			if (req_s1 == REQ_START) begin
				busy_q <= !st_empty;
				if (!st_empty) begin
					row_bytes_q  <= RB_W'(seg);
					rows_total_q <= ROW_W'(h);
					byte_count_q <= '0;
					row_count_q  <= '0;
					row_base_q   <= st_base;
				end
			end else if (busy_q) begin
				byte_count_q <= bc_nxt;
				row_count_q  <= rc_nxt;
				row_base_q   <= base_nxt;
				if (wend) busy_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (fire) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) res_s2 <= res_nxt;
	end

	// stream packing
	assign m_axis_tdata = {(TDATA_W - TDATA_USED)'(0), res_s2.out_byte, res_s2.fetch_addr,
		res_s2.win_h, res_s2.win_w, res_s2.win_y, res_s2.win_x};
	assign m_axis_tuser = {res_s2.row_end, res_s2.out_valid, res_s2.fetch_valid,
		res_s2.window_empty};
	assign m_axis_tlast = res_s2.window_end;

endmodule

// ===== sv/mwpf_checker.sv =====
// ----------------------------------------------------------------------------
// mwpf_checker
// port-level checks on the result stream of the window fetch block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mwpf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [mwpf_pkg::TDATA_W-1:0]  m_axis_tdata,
	input logic [mwpf_pkg::TUSER_W-1:0]  m_axis_tuser,
	input logic                          m_axis_tlast
);
	import mwpf_pkg::*;

	logic empty_f, fetch_f, out_f, rend_f;
	logic win_zero;

	assign empty_f  = m_axis_tuser[0];
	assign fetch_f  = m_axis_tuser[1];
	assign out_f    = m_axis_tuser[2];
	assign rend_f   = m_axis_tuser[3];
	assign win_zero = (m_axis_tdata[4*WIN_W-1:0] == '0);

	// last byte of a window is also a row end and carries no further fetch
	`ASSERT_IMPL(a_wend_is_row_end, m_axis_tvalid && m_axis_tlast,
		out_f && rend_f && !fetch_f, "window end without row end or with a fetch")

	// an empty window fetches nothing and reports no window
	`ASSERT_IMPL(a_empty_no_fetch, m_axis_tvalid && empty_f,
		!fetch_f && !out_f && win_zero, "empty window with fetch or window fields")

	// a returned byte never carries window fields
	`ASSERT_IMPL(a_data_no_window, m_axis_tvalid && out_f,
		win_zero && !empty_f, "data result carries window fields")

	// a stalled result holds
	`ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"result changed under stall")

endmodule

bind mirrored_window_pixel_fetch_top mwpf_checker u_mwpf_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the mirrored window pixel fetch block: a directed
// table and then randomized window sequences are pushed through the input
// stream. A local model of the clamp, align and fetch order predicts every
// result transaction, and each field is checked in order against the result
// stream under varying idle and stall patterns
// ----------------------------------------------------------------------------
module testbench;

	import mwpf_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEMS_PER_PHASE = 275;
	localparam int DIRECTED_ROWS   = 38;
	localparam int HOLD_CYCLES     = 80;
	localparam int MAX_FETCH_RUN   = 64;

	typedef enum logic [1:0] {
		STEP_CFG,
		STEP_START,
		STEP_DATA
	} step_kind_t;

	// how a directed row gets its expectation
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_ZERO,
		CHK_EMPTY
	} chk_kind_t;

	typedef struct packed {
		step_kind_t          kind;
		reg_idx_t            idx;
		logic [COORD_W-1:0]  val;
		logic [BYTE_W-1:0]   fb;
		chk_kind_t           chk;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic [TUSER_W-1:0]   m_axis_tuser;
	logic                 m_axis_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data = '0;

	// configuration copy, as last written
	logic [COORD_W-1:0]   req_left = '0;
	logic [COORD_W-1:0]   req_top = '0;
	logic [COORD_W-1:0]   req_width = '0;
	logic [COORD_W-1:0]   req_height = '0;
	logic                 mirror_on = 1'b1;

	// fetch sequencer state
	logic [RB_W-1:0]      bytes_per_row = '0;
	logic [ROW_W-1:0]     rows_in_window = '0;
	logic [ROW_W-1:0]     rows_done = '0;
	logic [RB_W-1:0]      col_pos = '0;
	logic [ADDR_W-1:0]    row_start_addr = '0;
	logic                 fetching = 1'b0;

	result_t              awaited_results[$];
	result_t              head_result;
	int                   mismatches = 0;
	int                   work_items = 0;
	int                   cycle_count = 0;
	int                   tx_idle_pct = 0;
	int                   rx_stall_pct = 0;
	// hold-off request toggles, the receiver follows it with its own copy
	bit                   rx_hold_req = 1'b0;
	bit                   rx_hold_ack = 1'b0;
	int                   rx_hold_left = 0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// data while idle, then start on the all-zero reset rectangle
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'hA5, CHK_ZERO},
		'{STEP_START, REG_RECT_LEFT,     13'd0,    8'h00, CHK_EMPTY},
		// 8 x 2 mirrored window at the origin, one full pass
		'{STEP_CFG,   REG_RECT_WIDTH,    13'd8,    8'h00, CHK_MODEL},
		'{STEP_CFG,   REG_RECT_HEIGHT,   13'd2,    8'h00, CHK_MODEL},
		'{STEP_START, REG_RECT_LEFT,     13'd0,    8'hFF, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'h00, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'hFF, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'h12, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'h34, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'h5A, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'hC3, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'h0F, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'hF0, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'hFF, CHK_ZERO},
		// most negative and largest left edge both clamp to nothing
		'{STEP_CFG,   REG_RECT_LEFT,     13'h1000, 8'h00, CHK_MODEL},
		'{STEP_START, REG_RECT_LEFT,     13'd0,    8'h00, CHK_EMPTY},
		'{STEP_CFG,   REG_RECT_LEFT,     13'h0FFF, 8'h00, CHK_MODEL},
		'{STEP_START, REG_RECT_LEFT,     13'd0,    8'h00, CHK_EMPTY},
		// bottom right corner, unmirrored, mirror flipped halfway through
		'{STEP_CFG,   REG_MIRROR_ENABLE, 13'd0,    8'h00, CHK_MODEL},
		'{STEP_CFG,   REG_RECT_LEFT,     13'd1866, 8'h00, CHK_MODEL},
		'{STEP_CFG,   REG_RECT_TOP,      13'd1403, 8'h00, CHK_MODEL},
		'{STEP_CFG,   REG_RECT_WIDTH,    13'h0FFF, 8'h00, CHK_MODEL},
		'{STEP_CFG,   REG_RECT_HEIGHT,   13'h0FFF, 8'h00, CHK_MODEL},
		'{STEP_START, REG_RECT_LEFT,     13'd0,    8'h00, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'h81, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'h7E, CHK_MODEL},
		'{STEP_CFG,   REG_MIRROR_ENABLE, 13'd1,    8'h00, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'h3C, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'hC3, CHK_MODEL},
		// unaligned left, negative top, restart while busy
		'{STEP_CFG,   REG_RECT_LEFT,     13'd5,    8'h00, CHK_MODEL},
		'{STEP_CFG,   REG_RECT_TOP,      13'h1FF9, 8'h00, CHK_MODEL},
		'{STEP_CFG,   REG_RECT_WIDTH,    13'd3,    8'h00, CHK_MODEL},
		'{STEP_CFG,   REG_RECT_HEIGHT,   13'd10,   8'h00, CHK_MODEL},
		'{STEP_START, REG_RECT_LEFT,     13'd0,    8'h00, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'h11, CHK_MODEL},
		'{STEP_START, REG_RECT_LEFT,     13'd0,    8'h00, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'h22, CHK_MODEL},
		'{STEP_DATA,  REG_RECT_LEFT,     13'd0,    8'h33, CHK_MODEL}
	};

	mirrored_window_pixel_fetch_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// frame buffer address of the byte at the current column
	function automatic logic [ADDR_W-1:0] next_fetch_addr();
		logic [RB_W-1:0] off;
		off = mirror_on ? bytes_per_row - 1'b1 - col_pos : col_pos;
		return row_start_addr + ADDR_W'(off);
	endfunction

	// expected result of one input transaction, advances the sequencer state
	function automatic result_t fetch_result(input req_type_t req, input logic [BYTE_W-1:0] fb);
		result_t r;
		int x, y, w, h, x0, x1, aw;
		logic at_row_end, at_win_end;
		r = '0;
		if (req == REQ_START) begin
			x = $signed(req_left);
			y = $signed(req_top);
			w = $signed(req_width);
			h = $signed(req_height);
			fetching = 1'b0;
			// clamp to the panel
			if (x < 0) begin
				w += x;
				x = 0;
			end
			if (y < 0) begin
				h += y;
				y = 0;
			end
			if (x + w > PANEL_WIDTH) w = PANEL_WIDTH - x;
			if (y + h > PANEL_HEIGHT) h = PANEL_HEIGHT - y;
			if (w <= 0 || h <= 0) begin
				r.window_empty = 1'b1;
				return r;
			end
			// widen outward to 4-pixel alignment
			x0 = x & ~3;
			x1 = (x + w + 3) & ~3;
			if (x1 > PANEL_WIDTH) x1 = PANEL_WIDTH;
			aw = x1 - x0;
			if (aw < 2) begin
				r.window_empty = 1'b1;
				return r;
			end
			bytes_per_row  = RB_W'(aw / 2);
			rows_in_window = ROW_W'(h);
			rows_done      = '0;
			col_pos        = '0;
			row_start_addr = ADDR_W'(y * PITCH + x0 / 2);
			fetching       = 1'b1;
			r.win_x        = WIN_W'(mirror_on ? PANEL_WIDTH - x1 : x0);
			r.win_y        = WIN_W'(y);
			r.win_w        = WIN_W'(aw);
			r.win_h        = WIN_W'(h);
			r.fetch_addr   = next_fetch_addr();
			r.fetch_valid  = 1'b1;
		end else if (fetching) begin
			at_row_end   = (col_pos + 1 >= bytes_per_row);
			at_win_end   = at_row_end && (rows_done + 1 >= rows_in_window);
			r.out_byte   = mirror_on ? {fb[3:0], fb[7:4]} : fb;
			r.out_valid  = 1'b1;
			r.row_end    = at_row_end;
			r.window_end = at_win_end;
			if (at_row_end) begin
				col_pos = '0;
				rows_done++;
				row_start_addr += ADDR_W'(PITCH);
			end else begin
				col_pos++;
			end
			if (at_win_end) begin
				fetching = 1'b0;
			end else begin
				r.fetch_addr  = next_fetch_addr();
				r.fetch_valid = 1'b1;
			end
		end
		return r;
	endfunction

	// one input transaction, then an optional sender gap
	task automatic offer_item(input req_type_t req, input logic [BYTE_W-1:0] fb,
		input chk_kind_t chk);
		result_t want;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= fb;
		do @(posedge clk); while (!s_axis_tready);
		if (req == REQ_START || fetching) work_items++;
		want = fetch_result(req, fb);
		if (chk != CHK_MODEL) begin
			want = '0;
			want.window_empty = (chk == CHK_EMPTY);
		end
		awaited_results.push_back(want);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	// leaves cfg_valid high, the caller lowers it after the last write
	task automatic cfg_write(input reg_idx_t idx, input logic [COORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RECT_LEFT:     req_left = val;
			REG_RECT_TOP:      req_top = val;
			REG_RECT_WIDTH:    req_width = val;
			REG_RECT_HEIGHT:   req_height = val;
			REG_MIRROR_ENABLE: mirror_on = val[0];
			default: ;
		endcase
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	// new rectangle, start, then the window's bytes with the odd abort or flip
	task automatic run_window();
		int i, pick, n_send;
		logic [COORD_W-1:0] v;
		wait_drained();
		pick = $urandom_range(4);
		for (i = 0; i <= REG_MIRROR_ENABLE; i++) begin
			if (i == pick || $urandom_range(1) == 1) begin
				n_send = $urandom_range(9);
				case (reg_idx_t'(i))
					REG_RECT_LEFT:
						v = n_send < 5 ? COORD_W'($urandom_range(60) - 20) :
							n_send < 7 ? COORD_W'(1800 + $urandom_range(90)) :
							n_send < 9 ? COORD_W'($urandom) : '0;
					REG_RECT_TOP:
						v = n_send < 5 ? COORD_W'($urandom_range(30) - 8) :
							n_send < 7 ? COORD_W'(1380 + $urandom_range(30)) :
							n_send < 9 ? COORD_W'($urandom) : '0;
					REG_RECT_WIDTH:
						v = n_send < 7 ? COORD_W'($urandom_range(48) - 4) :
							n_send == 7 ? 13'h0FFF :
							n_send == 8 ? COORD_W'($urandom) : COORD_W'($urandom_range(200));
					REG_RECT_HEIGHT:
						v = n_send < 7 ? COORD_W'($urandom_range(4) - 1) :
							n_send == 7 ? COORD_W'($urandom_range(30)) :
							n_send == 8 ? COORD_W'($urandom) : 13'h0FFF;
					default:
						v = COORD_W'($urandom_range(1));
				endcase
				cfg_write(reg_idx_t'(i), v);
			end
		end
		cfg_valid <= 1'b0;
		offer_item(REQ_START, BYTE_W'($urandom_range(255)), CHK_MODEL);
		n_send = fetching ? int'(bytes_per_row) * int'(rows_in_window) : 0;
		if (n_send > MAX_FETCH_RUN) n_send = $urandom_range(MAX_FETCH_RUN);
		if ($urandom_range(9) == 0) n_send = $urandom_range(n_send);
		for (i = 0; i < n_send; i++) begin
			// flip mirroring with a window half done
			if ($urandom_range(99) < 2) begin
				wait_drained();
				cfg_write(REG_MIRROR_ENABLE, COORD_W'(!mirror_on));
				cfg_valid <= 1'b0;
			end
			offer_item(REQ_DATA, BYTE_W'($urandom_range(255)), CHK_MODEL);
		end
		// stray bytes after those sent for the window, which may have been cut short
		if ($urandom_range(99) < 15)
			repeat ($urandom_range(3, 1))
				offer_item(REQ_DATA, BYTE_W'($urandom_range(255)), CHK_MODEL);
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (rx_hold_req != rx_hold_ack) begin
			rx_hold_ack = rx_hold_req;
			rx_hold_left = HOLD_CYCLES;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				$error("result transaction with no expectation waiting");
				mismatches++;
			end else begin
				head_result = awaited_results.pop_front();
				check_field("win_x", head_result.win_x, m_axis_tdata[10:0]);
				check_field("win_y", head_result.win_y, m_axis_tdata[21:11]);
				check_field("win_w", head_result.win_w, m_axis_tdata[32:22]);
				check_field("win_h", head_result.win_h, m_axis_tdata[43:33]);
				check_field("fetch_addr", head_result.fetch_addr, m_axis_tdata[64:44]);
				check_field("out_byte", head_result.out_byte, m_axis_tdata[72:65]);
				check_field("window_empty", head_result.window_empty, m_axis_tuser[0]);
				check_field("fetch_valid", head_result.fetch_valid, m_axis_tuser[1]);
				check_field("out_valid", head_result.out_valid, m_axis_tuser[2]);
				check_field("row_end", head_result.row_end, m_axis_tuser[3]);
				check_field("window_end", head_result.window_end, m_axis_tlast);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// stimulus
	initial begin
		int phase, phase_start;
		stim_row_t row;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[n]) begin
			row = directed_rows[n];
			case (row.kind)
				STEP_CFG: begin
					wait_drained();
					cfg_write(row.idx, row.val);
					if (n == DIRECTED_ROWS - 1 || directed_rows[n + 1].kind != STEP_CFG)
						cfg_valid <= 1'b0;
				end
				STEP_START: offer_item(REQ_START, row.fb, row.chk);
				default:    offer_item(REQ_DATA, row.fb, row.chk);
			endcase
		end

		// random windows under four idle patterns
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
					rx_hold_req = ~rx_hold_req;
					// keep offering while the receiver holds off, so the input stalls
					repeat (8)
						offer_item(REQ_DATA, BYTE_W'($urandom_range(255)), CHK_MODEL);
				end
				1: begin
					tx_idle_pct = 86;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 86;
				end
				default: begin
					tx_idle_pct = 37;
					rx_stall_pct = 37;
				end
			endcase
			phase_start = work_items;
			while (work_items - phase_start < ITEMS_PER_PHASE) begin
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(4, 1))
						offer_item(req_type_t'($urandom_range(1)),
							BYTE_W'($urandom_range(255)), CHK_MODEL);
				else
					run_window();
			end
		end

		// let the pipeline settle and catch any stray result
		rx_stall_pct = 0;
		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/mwpf_pkg.sv
sv/mirrored_window_pixel_fetch_top.sv
sv/mwpf_checker.sv
tb/testbench.sv
